FILE: rtl/scrs_pkg.sv
// Shared types and constants for the SEI caption range scanner.
// No dependencies.
package scrs_pkg;

  localparam int unsigned MAX_UNIT_BYTES = 65536;
  localparam int unsigned OFF_W          = $clog2(MAX_UNIT_BYTES + 1);
  localparam int unsigned SIZE_W         = OFF_W + 1;
  localparam int unsigned CODE_W         = 16;
  localparam int unsigned REC_W          = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] BYTE_ESCAPE = 8'hFF;
  localparam logic [7:0] BYTE_EMUL   = 8'h03;
  localparam logic [7:0] BYTE_ESC_VAL = 8'd255;

  typedef struct packed {
    logic             has_range;
    logic             has_status;
    logic             ok;
    logic [REC_W-1:0] start;
    logic [REC_W-1:0] length;
  } scrs_event_t;

endpackage

FILE: rtl/scrs_front.sv
// Front end: parses SEI bytes and classifies each into a range/status event.
// Depends on scrs_pkg.
module scrs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  input  logic [scrs_pkg::CODE_W-1:0]  caption_type_code_i,
  output logic                         push_o,
  output scrs_pkg::scrs_event_t        event_o
);

  typedef enum logic [2:0] {
    PH_NAL, PH_START, PH_TYPE, PH_SIZE, PH_PAYLOAD, PH_HALT
  } phase_e;

  phase_e                              phase_q, phase_d;
  logic [scrs_pkg::OFF_W-1:0]          offset_q, offset_d;
  logic [scrs_pkg::CODE_W-1:0]         type_q, type_d;
  logic [scrs_pkg::SIZE_W-1:0]         size_q, size_d;
  logic [scrs_pkg::OFF_W-1:0]          seen_q, seen_d;
  logic [15:0]                         recent_q, recent_d;
  logic [scrs_pkg::OFF_W-1:0]          mstart_q, mstart_d;
  logic                                ok_q, ok_d;

  logic                                complete;
  logic                                status_ok;
  logic [7:0]                          add_val;
  logic [scrs_pkg::CODE_W:0]           type_sum;
  logic [scrs_pkg::SIZE_W-1:0]         size_sum;
  logic [scrs_pkg::OFF_W-1:0]          msg_len;

  assign add_val  = (data_byte_i == scrs_pkg::BYTE_ESCAPE) ? scrs_pkg::BYTE_ESC_VAL
                                                           : data_byte_i;
  assign type_sum = {1'b0, type_q} + (scrs_pkg::CODE_W+1)'(add_val);
  assign size_sum = size_q + scrs_pkg::SIZE_W'(add_val);
  assign msg_len  = offset_q - mstart_q + scrs_pkg::OFF_W'(1);

  always_comb begin
    phase_d  = phase_q;
    offset_d = offset_q;
    type_d   = type_q;
    size_d   = size_q;
    seen_d   = seen_q;
    recent_d = recent_q;
    mstart_d = mstart_q;
    ok_d     = ok_q;
    complete = 1'b0;

    if (phase_q != PH_HALT && offset_q >= scrs_pkg::OFF_W'(scrs_pkg::MAX_UNIT_BYTES)) begin
      ok_d    = 1'b0;
      phase_d = PH_HALT;
    end

    case (phase_d)
      PH_NAL: begin
        phase_d = PH_START;
      end
      PH_START: begin
        if (!last_byte_i) begin
          mstart_d = offset_q;
          size_d   = '0;
          seen_d   = '0;
          type_d   = scrs_pkg::CODE_W'(add_val);
          phase_d  = (data_byte_i == scrs_pkg::BYTE_ESCAPE) ? PH_TYPE : PH_SIZE;
        end
      end
      PH_TYPE: begin
        type_d = type_sum[scrs_pkg::CODE_W] ? '1 : type_sum[scrs_pkg::CODE_W-1:0];
        if (data_byte_i != scrs_pkg::BYTE_ESCAPE) begin
          phase_d = PH_SIZE;
        end
      end
      PH_SIZE: begin
        size_d = size_sum;
        if (size_sum > scrs_pkg::SIZE_W'(scrs_pkg::MAX_UNIT_BYTES)) begin
          ok_d    = 1'b0;
          phase_d = PH_HALT;
        end else if (data_byte_i != scrs_pkg::BYTE_ESCAPE) begin
          phase_d = PH_PAYLOAD;
          if (size_sum == '0) begin
            complete = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (seen_q >= scrs_pkg::OFF_W'(2) && recent_q == 16'h0000 &&
            data_byte_i == scrs_pkg::BYTE_EMUL) begin
          size_d = size_q + scrs_pkg::SIZE_W'(1);
        end
        seen_d = seen_q + scrs_pkg::OFF_W'(1);
        if ({1'b0, seen_d} >= size_d) begin
          complete = 1'b1;
        end
      end
      default: ;
    endcase

    recent_d = {recent_q[7:0], data_byte_i};
    if (offset_q < scrs_pkg::OFF_W'(scrs_pkg::MAX_UNIT_BYTES)) begin
      offset_d = offset_q + scrs_pkg::OFF_W'(1);
    end

    event_o.has_range = complete && (type_d == caption_type_code_i);
    event_o.start     = mstart_d[scrs_pkg::REC_W-1:0];
    event_o.length    = msg_len[scrs_pkg::REC_W-1:0];
    if (complete) begin
      phase_d = PH_START;
    end

    status_ok          = ok_d && (phase_d == PH_START || phase_d == PH_NAL);
    event_o.has_status = last_byte_i;
    event_o.ok         = status_ok;

    if (last_byte_i) begin
      phase_d  = PH_NAL;
      offset_d = '0;
      type_d   = '0;
      size_d   = '0;
      seen_d   = '0;
      recent_d = '0;
      mstart_d = '0;
      ok_d     = 1'b1;
    end
  end

  assign push_o = accept_i && (event_o.has_range || event_o.has_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NAL;
      offset_q <= '0;
      type_q   <= '0;
      size_q   <= '0;
      seen_q   <= '0;
      recent_q <= '0;
      mstart_q <= '0;
      ok_q     <= 1'b1;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      type_q   <= type_d;
      size_q   <= size_d;
      seen_q   <= seen_d;
      recent_q <= recent_d;
      mstart_q <= mstart_d;
      ok_q     <= ok_d;
    end
  end

endmodule

FILE: rtl/scrs_queue.sv
// Small event FIFO between parser front end and record back end.
// Depends on scrs_pkg.
module scrs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  scrs_pkg::scrs_event_t push_data_i,
  input  logic                  pop_i,
  output scrs_pkg::scrs_event_t pop_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  scrs_pkg::scrs_event_t             mem_q [scrs_pkg::QUEUE_DEPTH];
  logic [scrs_pkg::QUEUE_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [scrs_pkg::QUEUE_AW:0]       count_q;
  logic                              do_push, do_pop;

  assign full_o     = count_q == (scrs_pkg::QUEUE_AW+1)'(scrs_pkg::QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + scrs_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + scrs_pkg::QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (scrs_pkg::QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (scrs_pkg::QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/scrs_back.sv
// Back end: expands queued events into range and status records.
// Depends on scrs_pkg.
module scrs_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  scrs_pkg::scrs_event_t        event_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic                         is_status_o,
  output logic [scrs_pkg::REC_W-1:0]   range_start_o,
  output logic [scrs_pkg::REC_W-1:0]   range_length_o,
  output logic                         scan_valid_o,
  output logic                         final_record_o
);

  logic                        valid_q;
  logic                        pend_q;
  logic                        pend_ok_q;
  logic                        status_q;
  logic [scrs_pkg::REC_W-1:0]  start_q, length_q;
  logic                        scan_ok_q;
  logic                        can_load;

  assign can_load = !valid_q || ready_i;
  assign pop_o    = can_load && !pend_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      pend_q    <= 1'b0;
      pend_ok_q <= 1'b0;
      status_q  <= 1'b0;
      start_q   <= '0;
      length_q  <= '0;
      scan_ok_q <= 1'b0;
    end else if (can_load) begin
      if (pend_q) begin
        valid_q   <= 1'b1;
        status_q  <= 1'b1;
        start_q   <= '0;
        length_q  <= '0;
        scan_ok_q <= pend_ok_q;
        pend_q    <= 1'b0;
      end else if (!empty_i) begin
        valid_q <= 1'b1;
        if (event_i.has_range) begin
          status_q  <= 1'b0;
          start_q   <= event_i.start;
          length_q  <= event_i.length;
          scan_ok_q <= 1'b0;
          pend_q    <= event_i.has_status;
          pend_ok_q <= event_i.ok;
        end else begin
          status_q  <= 1'b1;
          start_q   <= '0;
          length_q  <= '0;
          scan_ok_q <= event_i.ok;
        end
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  assign valid_o        = valid_q;
  assign is_status_o    = status_q;
  assign range_start_o  = start_q;
  assign range_length_o = length_q;
  assign scan_valid_o   = scan_ok_q;
  assign final_record_o = status_q;

endmodule

FILE: rtl/sei_caption_range_scanner.sv
// Top level of the SEI caption range scanner: config register, front end,
// event queue and record back end. Depends on scrs_pkg, scrs_front,
// scrs_queue, scrs_back.
//
//  channel   | direction | handshake                   | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata[7:0] byte, tlast end of unit
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata start/len/valid, tuser, tlast
//  cfg       | in        | cfg_we_i                    | cfg_wdata_i caption type code
//
// One byte per cycle in; the front end parses each accepted byte as it comes.
// Records leave one per cycle, while m_axis_tready is high, through a registered output;
// a byte that ends a caption message on the last byte yields one event that the back end
// expands into two records. Input stalls only when the 4-entry event queue is full.
// Reset (async, active low) clears the parser, queue and output; no sweep.
module sei_caption_range_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] range_start, [31:16] range_length,
                                      // [32] scan_valid, [39:33] zero
  output logic        m_axis_tuser,   // [0] is_status
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [scrs_pkg::CODE_W-1:0]  caption_code_q;
  logic                         accept;
  logic                         push;
  logic                         pop;
  logic                         full;
  logic                         empty;
  scrs_pkg::scrs_event_t        push_event;
  scrs_pkg::scrs_event_t        pop_event;
  logic [scrs_pkg::REC_W-1:0]   range_start;
  logic [scrs_pkg::REC_W-1:0]   range_length;
  logic                         scan_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caption_code_q <= scrs_pkg::CODE_W'(4);
    end else if (cfg_we_i) begin
      caption_code_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  scrs_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .data_byte_i         (s_axis_tdata),
    .last_byte_i         (s_axis_tlast),
    .caption_type_code_i (caption_code_q),
    .push_o              (push),
    .event_o             (push_event)
  );

  scrs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_event),
    .pop_i       (pop),
    .pop_data_o  (pop_event),
    .full_o      (full),
    .empty_o     (empty)
  );

  scrs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .event_i        (pop_event),
    .empty_i        (empty),
    .pop_o          (pop),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .is_status_o    (m_axis_tuser),
    .range_start_o  (range_start),
    .range_length_o (range_length),
    .scan_valid_o   (scan_valid),
    .final_record_o (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, scan_valid, range_length, range_start};

endmodule
